### rtl/asm_pkg.sv
// asm_pkg: shared constants and types of the adc scan smoother
// no dependencies; used by the channel interfaces, the smoothing unit and the top level

package asm_pkg;

  // default configuration of the scanner
  localparam int PAUSE_TICKS_DEF = 10;
  localparam int CHANNELS_DEF    = 8;

  // fixed field widths
  localparam int SAMPLE_W = 10;
  localparam int SMOOTH_W = 4;
  localparam int CH_OUT_W = 3;
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 2;

  // register index of the smoothing weight
  localparam int REG_SMOOTHING = 0;

  // request to the smoothing unit
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] old_value;
    logic [SMOOTH_W-1:0] weight;
    logic [SAMPLE_W-1:0] sample;
  } smooth_req_t;

  // answer of the smoothing unit
  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] value;
  } smooth_rsp_t;

endpackage

### rtl/asm_in_if.sv
// asm_in_if: poll tick channel of the adc scan smoother
// depends on asm_pkg for field widths

interface asm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         conversion_done;
  logic [asm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, conversion_done, sample, input ready);
  modport sink (input valid, conversion_done, sample, output ready);
endinterface

### rtl/asm_out_if.sv
// asm_out_if: result channel of the adc scan smoother
// depends on asm_pkg for field widths

interface asm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         start_conversion;
  logic                         select_valid;
  logic [asm_pkg::CH_OUT_W-1:0] next_channel;
  logic                         updated;
  logic [asm_pkg::CH_OUT_W-1:0] channel;
  logic [asm_pkg::SAMPLE_W-1:0] smoothed;
  logic [asm_pkg::BYTE_W-1:0]   high_byte;
  logic                         packed_index;
  logic [asm_pkg::BYTE_W-1:0]   packed_byte;

  modport source (output valid, start_conversion, select_valid, next_channel, updated,
                  channel, smoothed, high_byte, packed_index, packed_byte, input ready);
  modport sink (input valid, start_conversion, select_valid, next_channel, updated,
                channel, smoothed, high_byte, packed_index, packed_byte, output ready);
endinterface

### rtl/asm_smooth_unit.sv
// asm_smooth_unit: computes (old*s + sample)/(s+1) on one shared adder
// 4 shift-add multiply steps, then 10 restoring divide steps; depends on asm_pkg

module asm_smooth_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  asm_pkg::smooth_req_t req,
  output asm_pkg::smooth_rsp_t rsp
);

  localparam int ACC_W = asm_pkg::SAMPLE_W + asm_pkg::SMOOTH_W;
  localparam int REM_W = asm_pkg::SMOOTH_W;
  localparam int DIV_W = asm_pkg::SMOOTH_W + 1;
  localparam int Q_W   = asm_pkg::SAMPLE_W;

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_DIV  = 2'd2;

  localparam logic [3:0] MUL_LAST = 4'(asm_pkg::SMOOTH_W - 1);
  localparam logic [3:0] DIV_LAST = 4'(Q_W - 1);

  logic [1:0]                   state_r, state_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;
  logic [ACC_W-1:0]             acc_r, acc_nxt;
  logic [ACC_W-1:0]             mcand_r, mcand_nxt;
  logic [asm_pkg::SMOOTH_W-1:0] mult_r, mult_nxt;
  logic [DIV_W-1:0]             div_r, div_nxt;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [Q_W-1:0]               quo_r, quo_nxt;
  logic                         done_r, done_nxt;

  // shared add/subtract unit
  logic [ACC_W-1:0] add_a, add_b;
  logic             add_sub;
  logic [ACC_W:0]   add_y;
  logic             neg;

  assign add_y = add_sub ? ({1'b0, add_a} - {1'b0, add_b}) : ({1'b0, add_a} + {1'b0, add_b});
  assign neg   = add_y[ACC_W];

  // operand selection
  always_comb begin
    add_a   = acc_r;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      U_MUL: begin
        add_a = acc_r;
        add_b = mult_r[0] ? mcand_r : '0;
      end
      U_DIV: begin
        add_a   = ACC_W'({rem_r, quo_r[Q_W-1]});
        add_b   = ACC_W'(div_r);
        add_sub = 1'b1;
      end
      default: begin
        add_a = acc_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      U_IDLE: begin
        if (req.start) begin
          acc_nxt   = ACC_W'(req.sample);
          mcand_nxt = ACC_W'(req.old_value);
          mult_nxt  = req.weight;
          div_nxt   = DIV_W'(req.weight) + DIV_W'(1);
          cnt_nxt   = '0;
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        acc_nxt   = add_y[ACC_W-1:0];
        mcand_nxt = mcand_r << 1;
        mult_nxt  = mult_r >> 1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == MUL_LAST) begin
          // high part is below the divisor since the quotient fits 10 bits
          rem_nxt   = add_y[ACC_W-1:Q_W];
          quo_nxt   = add_y[Q_W-1:0];
          cnt_nxt   = '0;
          state_nxt = U_DIV;
        end
      end
      U_DIV: begin
        rem_nxt = neg ? {rem_r[REM_W-2:0], quo_r[Q_W-1]} : add_y[REM_W-1:0];
        quo_nxt = {quo_r[Q_W-2:0], ~neg};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          done_nxt  = 1'b1;
          state_nxt = U_IDLE;
        end
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.value = quo_r;

endmodule

### rtl/adc_scan_smoother.sv
// adc_scan_smoother: round-robin converter scan with per-channel exponential smoothing
// a tick without update yields its result in the cycle after acceptance
// a tick that completes a conversion runs 4 multiply and 10 divide steps
// on the shared adder of asm_smooth_unit, between its start and its write-back
// throughput: one tick per cycle while no update runs and the result channel does not stall; not ready during an update
// reset (rst_n, synchronous): pausing, channel 0, stored values and packed bytes zero

module adc_scan_smoother #(
  parameter int PAUSE_TICKS = asm_pkg::PAUSE_TICKS_DEF,
  parameter int CHANNELS    = asm_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  asm_in_if.sink                      in_bus,
  asm_out_if.source                   out_bus,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [asm_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [asm_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [asm_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CH_W  = $clog2(CHANNELS);
  localparam int PB    = (CHANNELS + 3) / 4;
  localparam int PB_W  = (PB > 1) ? $clog2(PB) : 1;
  localparam int SW    = asm_pkg::SAMPLE_W;
  localparam int BW    = asm_pkg::BYTE_W;
  localparam int OW    = asm_pkg::CH_OUT_W;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
  localparam logic [7:0]      PAUSE_END = 8'(PAUSE_TICKS);
  localparam logic [asm_pkg::PADDR_W-1:0] SMOOTHING_ADDR =
    asm_pkg::PADDR_W'(asm_pkg::REG_SMOOTHING * 4);

  // configuration register
  logic [asm_pkg::SMOOTH_W-1:0] smoothing_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == SMOOTHING_ADDR) ? asm_pkg::CFG_W'(smoothing_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_r <= '0;
    end else if (cfg_wr && (cfg_paddr == SMOOTHING_ADDR)) begin
      smoothing_r <= cfg_pwdata[asm_pkg::SMOOTH_W-1:0];
    end
  end

  // scan state
  logic [7:0]      pause_r, pause_nxt;
  logic            converting_r, converting_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            busy_r, busy_nxt;
  logic [SW-1:0]   values_r [CHANNELS];
  logic [SW-1:0]   values_nxt [CHANNELS];
  logic [BW-1:0]   low_r [PB];
  logic [BW-1:0]   low_nxt [PB];

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_start_r, out_start_nxt;
  logic          out_sel_r, out_sel_nxt;
  logic [OW-1:0] out_next_r, out_next_nxt;
  logic          out_upd_r, out_upd_nxt;
  logic [OW-1:0] out_ch_r, out_ch_nxt;
  logic [SW-1:0] out_val_r, out_val_nxt;
  logic [BW-1:0] out_hi_r, out_hi_nxt;
  logic          out_pidx_r, out_pidx_nxt;
  logic [BW-1:0] out_pbyte_r, out_pbyte_nxt;

  logic                 in_ready;
  logic                 in_acc;
  logic                 out_take;
  asm_pkg::smooth_req_t req;
  asm_pkg::smooth_rsp_t rsp;

  logic [CH_W-1:0] ch_next;
  logic [PB_W-1:0] bi;
  logic [2:0]      bit_pos;
  logic [BW-1:0]   new_byte;

  assign in_ready     = !busy_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = in_ready;
  assign in_acc       = in_bus.valid && in_ready;
  assign out_take     = out_valid_r && out_bus.ready;

  // smoothing request on a completed conversion
  assign req.start     = in_acc && converting_r && in_bus.conversion_done;
  assign req.old_value = values_r[ch_r];
  assign req.weight    = smoothing_r;
  assign req.sample    = in_bus.sample;

  asm_smooth_unit u_smooth (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // packed low-bit byte of the current channel
  assign ch_next = (ch_r == CH_LAST) ? '0 : ch_r + CH_W'(1);
  assign bi      = PB_W'(ch_r >> 2);
  assign bit_pos = {ch_r[1:0], 1'b0};

  always_comb begin
    new_byte = low_r[bi];
    new_byte[bit_pos +: 2] = rsp.value[1:0];
  end

  // tick handling and write-back
  always_comb begin
    pause_nxt      = pause_r;
    converting_nxt = converting_r;
    ch_nxt         = ch_r;
    busy_nxt       = busy_r;
    values_nxt     = values_r;
    low_nxt        = low_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_start_nxt  = out_start_r;
    out_sel_nxt    = out_sel_r;
    out_next_nxt   = out_next_r;
    out_upd_nxt    = out_upd_r;
    out_ch_nxt     = out_ch_r;
    out_val_nxt    = out_val_r;
    out_hi_nxt     = out_hi_r;
    out_pidx_nxt   = out_pidx_r;
    out_pbyte_nxt  = out_pbyte_r;
    if (rsp.done) begin
      values_nxt[ch_r] = rsp.value;
      low_nxt[bi]      = new_byte;
      ch_nxt           = ch_next;
      pause_nxt        = '0;
      converting_nxt   = 1'b0;
      busy_nxt         = 1'b0;
      out_valid_nxt    = 1'b1;
      out_start_nxt    = 1'b0;
      out_sel_nxt      = 1'b1;
      out_next_nxt     = OW'(ch_next);
      out_upd_nxt      = 1'b1;
      out_ch_nxt       = OW'(ch_r);
      out_val_nxt      = rsp.value;
      out_hi_nxt       = rsp.value[SW-1:2];
      out_pidx_nxt     = bi[0];
      out_pbyte_nxt    = new_byte;
    end else if (in_acc) begin
      out_start_nxt = 1'b0;
      out_sel_nxt   = 1'b0;
      out_next_nxt  = '0;
      out_upd_nxt   = 1'b0;
      out_ch_nxt    = '0;
      out_val_nxt   = '0;
      out_hi_nxt    = '0;
      out_pidx_nxt  = 1'b0;
      out_pbyte_nxt = '0;
      if (!converting_r) begin
        out_valid_nxt = 1'b1;
        if (pause_r < PAUSE_END) begin
          pause_nxt = pause_r + 8'd1;
        end else begin
          converting_nxt = 1'b1;
          out_start_nxt  = 1'b1;
        end
      end else if (in_bus.conversion_done) begin
        busy_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r      <= '0;
      converting_r <= 1'b0;
      ch_r         <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        values_r[i] <= '0;
      end
      for (int j = 0; j < PB; j++) begin
        low_r[j] <= '0;
      end
    end else begin
      pause_r      <= pause_nxt;
      converting_r <= converting_nxt;
      ch_r         <= ch_nxt;
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      values_r     <= values_nxt;
      low_r        <= low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_start_r <= out_start_nxt;
    out_sel_r   <= out_sel_nxt;
    out_next_r  <= out_next_nxt;
    out_upd_r   <= out_upd_nxt;
    out_ch_r    <= out_ch_nxt;
    out_val_r   <= out_val_nxt;
    out_hi_r    <= out_hi_nxt;
    out_pidx_r  <= out_pidx_nxt;
    out_pbyte_r <= out_pbyte_nxt;
  end

  // result channel
  assign out_bus.valid            = out_valid_r;
  assign out_bus.start_conversion = out_start_r;
  assign out_bus.select_valid     = out_sel_r;
  assign out_bus.next_channel     = out_next_r;
  assign out_bus.updated          = out_upd_r;
  assign out_bus.channel          = out_ch_r;
  assign out_bus.smoothed         = out_val_r;
  assign out_bus.high_byte        = out_hi_r;
  assign out_bus.packed_index     = out_pidx_r;
  assign out_bus.packed_byte      = out_pbyte_r;

`ifndef NO_ASSERTIONS
  // no tick is taken while a smoothing update is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_bus.ready)
    else $error("tick accepted during smoothing update");

  // the unit answers only for a request that is in flight
  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> busy_r)
    else $error("smoothing answer without request");

  // a pending update result always leaves the block pausing
  a_update_pausing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_upd_r) |-> !converting_r)
    else $error("converting while update result pending");

  // a start request and an update never share one result
  a_start_xor_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_start_r && out_upd_r))
    else $error("start and update in one result");

  // a request while converting with done set hands off to the unit
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("smoothing request not tracked");
`endif

endmodule
